[sv/array_table_search_assert.svh]
// Assertion macros shared by the table search RTL.
`ifndef ARRAY_TABLE_SEARCH_ASSERT_SVH
`define ARRAY_TABLE_SEARCH_ASSERT_SVH

// Checks that a property holds on every clock edge outside reset.
`define ATS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition on one edge is followed by another on the next edge.
`define ATS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`endif

[sv/ats_pkg.sv]
// Package of types, codes and constants for the table search block.
package ats_pkg;

  // Field widths of the channels and the length register.
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 9;

  // Default number of table entries.
  localparam int unsigned DEPTH_DEFAULT = 256;

  // Length register value after reset.
  localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RESP,
    S_LIN,
    S_BIN_ADDR,
    S_BIN_CMP
  } state_e;

endpackage

[sv/ats_in_if.sv]
// Input channel of the table search block: operation, index, value and mode.
interface ats_in_if;
  import ats_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [INDEX_W-1:0] entry_index;
  value_t             value;
  logic               use_binary;

  modport source (output valid, func, entry_index, value, use_binary, input ready);
  modport sink   (input valid, func, entry_index, value, use_binary, output ready);
endinterface

[sv/ats_out_if.sv]
// Result channel of the table search block: status and matching index.
interface ats_out_if;
  import ats_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  found_index;

  modport source (output valid, status, found_index, input ready);
  modport sink   (input valid, status, found_index, output ready);
endinterface

[sv/ats_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module ats_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/array_table_search.sv]
// Top level of the table search block: table RAM, sequencer and compare unit.
//
// The block keeps a table of signed 32-bit words in one RAM of TABLE_DEPTH
// entries, of which the length register selects how many are in use (values
// above TABLE_DEPTH act as TABLE_DEPTH). Each input transfer appends, writes at
// an index, or searches for a key, and yields one result transfer unless a
// length write comes before the result reaches the output register. After
// reset, and after every write of the length register, the block clears the
// whole table and the append pointer in a pass over every address, during which
// it takes no item. Append and indexed write go from the idle state through the
// response state to the output register. A linear search reads one entry per
// cycle through the single RAM read port; a binary search makes each probe as
// an address state and then a compare of the registered read data. One item is
// in flight at a time; input ready is high only while the sequencer is idle,
// and a finished result waits in the output register while the next item runs.
module array_table_search #(
  parameter int unsigned TABLE_DEPTH = ats_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ats_pkg::LEN_W-1:0] cfg_wdata_i,
  ats_in_if.sink                    in_i,
  ats_out_if.source                 out_o
);
  import ats_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (LW > LEN_W) ? LW : LEN_W;
  localparam logic [CW-1:0] DEPTH_C   = CW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  state_e              state_q, state_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [LW-1:0]       ptr_q, ptr_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [LW-1:0]       cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       pidx_q, pidx_d;
  logic [LW-1:0]       lo_q, lo_d;
  logic [LW-1:0]       hp_q, hp_d;
  logic [AW-1:0]       mid_q, mid_d;
  value_t              key_q, key_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [INDEX_W-1:0]  res_found_q, res_found_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [INDEX_W-1:0]  out_found_q, out_found_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [VALUE_W-1:0]  ram_rdata;

  logic [CW-1:0]       len_ext;
  logic [CW-1:0]       used_len_c;
  logic [LW-1:0]       used_len;
  logic [LW-1:0]       span;
  logic [LW-1:0]       mid_w;
  logic [LW-1:0]       mid_ext;
  value_t              rd_word;
  logic                cmp_eq;
  logic                cmp_lt;
  logic                in_xfer;

  // Table storage.
  ats_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Length in use, limited to the table depth.
  assign len_ext    = CW'(len_q);
  assign used_len_c = (len_ext > DEPTH_C) ? DEPTH_C : len_ext;
  assign used_len   = LW'(used_len_c);

  // Binary search probe: midpoint of the half-open window [lo, hp).
  assign span    = hp_q - lo_q - LW'(1);
  assign mid_w   = lo_q + (span >> 1);
  assign mid_ext = LW'(mid_q);

  // Shared compare unit on the registered read data.
  assign rd_word = value_t'(ram_rdata);
  assign cmp_eq  = (rd_word == key_q);
  assign cmp_lt  = (rd_word < key_q);

  // Handshakes.
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.found_index = out_found_q;

  // Sequencer: next state, table access and result handling.
  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    ptr_d        = ptr_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pidx_d       = pidx_q;
    lo_d         = lo_q;
    hp_d         = hp_q;
    mid_d        = mid_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          key_d        = in_i.value;
          res_status_d = STAT_RANGE;
          res_found_d  = '0;
          state_d      = S_RESP;
          case (in_i.func)
            FUNC_APPEND: begin
              if (ptr_q < used_len) begin
                ram_we       = 1'b1;
                ram_waddr    = AW'(ptr_q);
                ram_wdata    = in_i.value;
                ptr_d        = ptr_q + LW'(1);
                res_status_d = STAT_OK;
              end
            end
            FUNC_WRITE: begin
              if (CW'(in_i.entry_index) < used_len_c) begin
                ram_we       = 1'b1;
                ram_waddr    = AW'(in_i.entry_index);
                ram_wdata    = in_i.value;
                res_status_d = STAT_OK;
              end
            end
            FUNC_SEARCH: begin
              cnt_d   = '0;
              pend_d  = 1'b0;
              lo_d    = '0;
              hp_d    = used_len;
              state_d = in_i.use_binary ? S_BIN_ADDR : S_LIN;
            end
            default: begin
              res_status_d = STAT_RANGE;
            end
          endcase
        end
      end

      S_LIN: begin
        // The entry read in the previous cycle is compared while the next is read.
        if (pend_q && cmp_eq) begin
          res_status_d = STAT_OK;
          res_found_d  = INDEX_W'(pidx_q);
          state_d      = S_RESP;
        end else if (cnt_q >= used_len) begin
          res_status_d = STAT_MISS;
          res_found_d  = '0;
          state_d      = S_RESP;
        end else begin
          ram_raddr = AW'(cnt_q);
          pidx_d    = AW'(cnt_q);
          pend_d    = 1'b1;
          cnt_d     = cnt_q + LW'(1);
        end
      end

      S_BIN_ADDR: begin
        if (lo_q >= hp_q) begin
          res_status_d = STAT_MISS;
          res_found_d  = '0;
          state_d      = S_RESP;
        end else begin
          ram_raddr = AW'(mid_w);
          mid_d     = AW'(mid_w);
          state_d   = S_BIN_CMP;
        end
      end

      S_BIN_CMP: begin
        if (cmp_eq) begin
          res_status_d = STAT_OK;
          res_found_d  = INDEX_W'(mid_q);
          state_d      = S_RESP;
        end else if (cmp_lt) begin
          lo_d    = mid_ext + LW'(1);
          state_d = S_BIN_ADDR;
        end else begin
          hp_d    = mid_ext;
          state_d = S_BIN_ADDR;
        end
      end

      S_RESP: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase

    // A length write rebuilds the table from empty.
    if (cfg_we_i) begin
      len_d   = cfg_wdata_i;
      ptr_d   = '0;
      clr_d   = '0;
      state_d = S_CLEAR;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      len_q       <= LEN_RESET;
      ptr_q       <= '0;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ptr_q       <= ptr_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    pidx_q       <= pidx_d;
    lo_q         <= lo_d;
    hp_q         <= hp_d;
    mid_q        <= mid_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
  end

  // Checks on the sequencer.
  `include "array_table_search_assert.svh"

  `ATS_ASSERT(a_ptr_bound, ptr_q <= used_len, "Append pointer beyond the length in use.")
  `ATS_ASSERT(a_lin_bound, (state_q == S_LIN) |-> (cnt_q <= used_len), "Scan ran past the table.")
  `ATS_ASSERT(a_bin_window, (state_q == S_BIN_CMP) |-> ((mid_ext >= lo_q) && (mid_ext < hp_q)), "Probe outside the search window.")
  `ATS_ASSERT_NEXT(a_short_op, (in_xfer && (in_i.func != FUNC_SEARCH) && !cfg_we_i), (state_q == S_RESP), "Append or write did not go to the response.")
  `ATS_ASSERT(a_out_src, $rose(out_valid_q) |-> $past(state_q == S_RESP), "Result appeared without a response step.")

endmodule
